/* sv/tlfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types and constants of the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package tlfq_pkg;

   localparam int LEVELS     = 3;
   localparam int ID_W       = 8;
   localparam int BURST_W    = 12;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int LVL_W      = 2;
   localparam int ENTRY_W    = ID_W + BURST_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic CMD_ARRIVE   = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IDLE       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_ONE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_TWO = 1'd1;

   localparam logic [BURST_W-1:0] QUANTUM_ONE_RESET = 12'd9;
   localparam logic [BURST_W-1:0] QUANTUM_TWO_RESET = 12'd16;

   // Internal level codes; the reported level is the code plus one.
   localparam logic [LVL_W-1:0] LVL_ONE   = 2'd0;
   localparam logic [LVL_W-1:0] LVL_TWO   = 2'd1;
   localparam logic [LVL_W-1:0] LVL_THREE = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic               command;
      logic [ID_W-1:0]    job_id;
      logic [BURST_W-1:0] burst_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     served_id;
      logic [LVL_W-1:0]    served_level;
      logic [BURST_W-1:0]  run_length;
      logic [TIME_W-1:0]   slice_start;
      logic                finished;
   } rsp_type;

endpackage

/* sv/tlfq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_req_if
// Request channel: command, job id and burst length with valid/ready.
// ----------------------------------------------------------------------------
interface tlfq_req_if;
   import tlfq_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic [ID_W-1:0]    job_id;
   logic [BURST_W-1:0] burst_length;

   modport source (output valid, command, job_id, burst_length, input ready);
   modport sink   (input valid, command, job_id, burst_length, output ready);
endinterface

/* sv/tlfq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_rsp_if
// Response channel: scheduling outcome of one request with valid/ready.
// ----------------------------------------------------------------------------
interface tlfq_rsp_if;
   import tlfq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     served_id;
   logic [LVL_W-1:0]    served_level;
   logic [BURST_W-1:0]  run_length;
   logic [TIME_W-1:0]   slice_start;
   logic                finished;

   modport source (output valid, status, served_id, served_level, run_length,
                   slice_start, finished, input ready);
   modport sink   (input valid, status, served_id, served_level, run_length,
                   slice_start, finished, output ready);
endinterface

/* sv/tlfq_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_entry_ram
// Simple dual-port entry memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlfq_entry_ram #(
   parameter int WORDS  = 48,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 20
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] entry_mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tlfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfq_ctrl
// Queue pointers, level selection, quantum accounting and request sequencing.
// ----------------------------------------------------------------------------
module tlfq_ctrl #(
   parameter int LEVEL_DEPTH = 16,
   parameter int ADDR_W      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  tlfq_pkg::req_type             req,
   output logic                          req_ready,
   input  logic                          out_free,
   input  logic [tlfq_pkg::BURST_W-1:0]  quantum_one,
   input  logic [tlfq_pkg::BURST_W-1:0]  quantum_two,
   output logic                          rd_en,
   output logic [ADDR_W-1:0]             rd_addr,
   input  logic [tlfq_pkg::ENTRY_W-1:0]  rd_data,
   output logic                          wr_en,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [tlfq_pkg::ENTRY_W-1:0]  wr_data,
   output logic                          result_load,
   output tlfq_pkg::rsp_type             result
);
   import tlfq_pkg::*;

   localparam int PTR_W = $clog2(LEVEL_DEPTH);
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(LEVEL_DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(LEVEL_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_TWO   = ADDR_W'(LEVEL_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_THREE = ADDR_W'(2 * LEVEL_DEPTH);

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff  [LEVELS];
   logic [PTR_W-1:0]   head_in  [LEVELS];
   logic [PTR_W-1:0]   tail_ff  [LEVELS];
   logic [PTR_W-1:0]   tail_in  [LEVELS];
   logic [CNT_W-1:0]   count_ff [LEVELS];
   logic [CNT_W-1:0]   count_in [LEVELS];
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;

   logic               accept;
   logic               any_work;
   logic [LVL_W-1:0]   sel_lvl;
   logic [PTR_W-1:0]   sel_head;
   logic [ID_W-1:0]    entry_id;
   logic [BURST_W-1:0] entry_rem;
   logic [BURST_W-1:0] quantum;
   logic               demote;
   logic [BURST_W-1:0] run_len;
   logic               next_full;
   logic [LVL_W-1:0]   dest_lvl;
   logic [PTR_W-1:0]   dest_tail;
   logic               push, pop;
   logic [LVL_W-1:0]   push_lvl;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] p);
      logic [ADDR_W-1:0] base;
      case (lvl)
         LVL_ONE: base = '0;
         LVL_TWO: base = BASE_TWO;
         default: base = BASE_THREE;
      endcase
      slot_addr = base + ADDR_W'(p);
   endfunction

   assign accept = req_valid && req_ready;

   // Highest non-empty level wins.
   always_comb begin
      any_work = (count_ff[0] != '0) || (count_ff[1] != '0) || (count_ff[2] != '0);
      if (count_ff[0] != '0) begin
         sel_lvl  = LVL_ONE;
         sel_head = head_ff[0];
      end else if (count_ff[1] != '0) begin
         sel_lvl  = LVL_TWO;
         sel_head = head_ff[1];
      end else begin
         sel_lvl  = LVL_THREE;
         sel_head = head_ff[2];
      end
   end

   assign rd_addr = slot_addr(sel_lvl, sel_head);

   // Quantum accounting on the entry that the memory returns.
   always_comb begin
      entry_id  = rd_data[ENTRY_W-1:BURST_W];
      entry_rem = rd_data[BURST_W-1:0];
      quantum   = (lvl_ff == LVL_ONE) ? quantum_one : quantum_two;
      demote    = (lvl_ff != LVL_THREE) && (entry_rem > quantum);
      run_len   = demote ? quantum : entry_rem;
      next_full = (lvl_ff == LVL_ONE) ? (count_ff[1] == CNT_FULL)
                                      : (count_ff[2] == CNT_FULL);
      // A full lower level sends the job back to its own tail.
      dest_lvl  = next_full ? lvl_ff : lvl_ff + LVL_W'(1);
      case (dest_lvl)
         LVL_ONE: dest_tail = tail_ff[0];
         LVL_TWO: dest_tail = tail_ff[1];
         default: dest_tail = tail_ff[2];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.command == CMD_DISPATCH) && any_work) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and queue operations.
   always_comb begin
      req_ready   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      result_load = 1'b0;
      result      = '0;
      push        = 1'b0;
      push_lvl    = LVL_ONE;
      pop         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (accept) begin
               if (req.command == CMD_ARRIVE) begin
                  result_load = 1'b1;
                  if (count_ff[0] == CNT_FULL) begin
                     result.status = STATUS_DROPPED;
                  end else begin
                     result.status = STATUS_ACCEPTED;
                     push          = 1'b1;
                     push_lvl      = LVL_ONE;
                     wr_en         = 1'b1;
                     wr_addr       = slot_addr(LVL_ONE, tail_ff[0]);
                     wr_data       = {req.job_id, req.burst_length};
                  end
               end else if (!any_work) begin
                  result_load   = 1'b1;
                  result.status = STATUS_IDLE;
               end else begin
                  rd_en = 1'b1;
               end
            end
         end
         ST_RUN: begin
            pop                 = 1'b1;
            result_load         = 1'b1;
            result.status       = STATUS_DISPATCHED;
            result.served_id    = entry_id;
            result.served_level = lvl_ff + LVL_W'(1);
            result.run_length   = run_len;
            result.slice_start  = elapsed_ff;
            result.finished     = !demote;
            if (demote) begin
               push     = 1'b1;
               push_lvl = dest_lvl;
               wr_en    = 1'b1;
               wr_addr  = slot_addr(dest_lvl, dest_tail);
               wr_data  = {entry_id, entry_rem - quantum};
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Pointer, count and time updates.
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         logic inc;
         logic dec;
         inc         = push && (push_lvl == LVL_W'(l));
         dec         = pop && (lvl_ff == LVL_W'(l));
         count_in[l] = count_ff[l] + CNT_W'(inc) - CNT_W'(dec);
         head_in[l]  = dec ? ptr_next(head_ff[l]) : head_ff[l];
         tail_in[l]  = inc ? ptr_next(tail_ff[l]) : tail_ff[l];
      end
      elapsed_in = (state_ff == ST_RUN) ? elapsed_ff + TIME_W'(run_len) : elapsed_ff;
      lvl_in     = accept ? sel_lvl : lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         elapsed_ff <= '0;
         lvl_ff     <= LVL_ONE;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         lvl_ff     <= lvl_in;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            tail_ff[l]  <= tail_in[l];
            count_ff[l] <= count_in[l];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CNT_FULL) && (count_ff[1] <= CNT_FULL) && (count_ff[2] <= CNT_FULL))
      else $error("level occupancy above depth");

   a_run_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> result_load)
      else $error("dispatch cycle without a result");

   a_run_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |=> (state_ff == ST_IDLE))
      else $error("dispatch held longer than one cycle");

   a_read_has_work: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (any_work && (count_ff[sel_lvl] != '0)))
      else $error("entry read from an empty level");

   a_drop_keeps_level: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.command == CMD_ARRIVE) && (count_ff[0] == CNT_FULL))
      |=> (count_ff[0] == CNT_FULL))
      else $error("dropped request changed level one");

endmodule

/* sv/three_level_feedback_queue_scheduler.sv */
`timescale 1ns / 1ps
// Three-level feedback queue scheduler. An arrive request appends a job to level one, or
// drops it when that level is full, and loads its response directly; a dispatch that finds
// work fetches the head entry from the single entry memory, whose read is registered, then
// charges it its quantum and writes any remaining burst back to a tail. A dispatch to an
// all-idle scheduler loads an idle response directly. Each request gives exactly one
// response, held in an output register, and a new request is taken only once that
// register is free or being emptied in the same cycle. The quanta are written through
// the csr port; the user must do so only while no request is in flight (unchecked).
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// Top level: quantum registers, entry memory, sequencer and response register.
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler #(
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   tlfq_req_if.sink                        req_chan,
   tlfq_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [tlfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlfq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tlfq_pkg::*;

   localparam int WORDS  = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W = $clog2(WORDS);

   logic [BURST_W-1:0] quantum_one_ff, quantum_one_in;
   logic [BURST_W-1:0] quantum_two_ff, quantum_two_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   req_type            req;
   logic               req_ready;
   logic               out_free;
   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic               result_load;
   rsp_type            result;

   assign req.command      = req_chan.command;
   assign req.job_id       = req_chan.job_id;
   assign req.burst_length = req_chan.burst_length;
   assign req_chan.ready   = req_ready;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   tlfq_entry_ram #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tlfq_ctrl #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req         (req),
      .req_ready   (req_ready),
      .out_free    (out_free),
      .quantum_one (quantum_one_ff),
      .quantum_two (quantum_two_ff),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .result_load (result_load),
      .result      (result)
   );

   always_comb begin
      quantum_one_in = quantum_one_ff;
      quantum_two_in = quantum_two_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_QUANTUM_ONE: quantum_one_in = csr_wdata;
            CSR_QUANTUM_TWO: quantum_two_in = csr_wdata;
            default: begin
               quantum_one_in = quantum_one_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_one_ff <= QUANTUM_ONE_RESET;
         quantum_two_ff <= QUANTUM_TWO_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         quantum_one_ff <= quantum_one_in;
         quantum_two_ff <= quantum_two_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.served_id    = rsp_data_ff.served_id;
   assign rsp_chan.served_level = rsp_data_ff.served_level;
   assign rsp_chan.run_length   = rsp_data_ff.run_length;
   assign rsp_chan.slice_start  = rsp_data_ff.slice_start;
   assign rsp_chan.finished     = rsp_data_ff.finished;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending response overwritten");

   a_quantum_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_en |=> ($stable(quantum_one_ff) && $stable(quantum_two_ff)))
      else $error("quantum changed without a write");

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> out_free)
      else $error("request taken while the response register is blocked");

endmodule
